FILE: rtl/core/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and codes for the indexed list: request and response
// payloads, request and status codes, command kinds and back-end states.
// ----------------------------------------------------------------------------
package ilir_pkg;

	// Request codes carried in req_type
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_GET    = 3'd2;
	localparam logic [2:0] OP_SET    = 3'd3;
	localparam logic [2:0] OP_REMOVE = 3'd4;
	localparam logic [2:0] OP_CLEAR  = 3'd5;

	// Status codes returned with every response
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [6:0]  position;
		logic [31:0] item_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] item_out;
		logic [6:0]  count_after;
	} rsp_t;

	// Storage work that a classified request leaves for the back end
	typedef enum logic [2:0] {
		K_NONE,
		K_WRITE,
		K_GET,
		K_SET,
		K_INS,
		K_REM
	} cmd_kind_t;

	// Control part of a queued command
	typedef struct packed {
		cmd_kind_t  kind;
		logic [1:0] status;
		logic [6:0] count_after;
		logic       shift;
	} cmd_ctrl_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_CAP,
		B_MOVE,
		B_DRAIN,
		B_WRITE,
		B_EMIT
	} back_state_t;

endpackage

FILE: rtl/core/ilir_front.sv
// ----------------------------------------------------------------------------
// ilir_front
// Accepts requests, checks them against the live count, decides status and
// new count, and pushes the remaining storage work into the command queue.
// ----------------------------------------------------------------------------
module ilir_front import ilir_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  req_t                          req,
	input  logic                          q_full,
	output logic                          push,
	output cmd_ctrl_t                     ctrl,
	output logic [$clog2(DEPTH)-1:0]      addr,
	output logic [$clog2(DEPTH)-1:0]      last,
	output logic [DATA_WIDTH-1:0]         item
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = CW + 7;
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [PW-1:0] ONE_P   = PW'(1);

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         cnt_next;
	logic [CW-1:0]         cnt_m1;
	logic [PW-1:0]         pos_w;
	logic [PW-1:0]         cnt_w;
	logic [DATA_WIDTH+31:0] item_ext;

	assign req_stall = q_full;
	assign push      = req_valid & ~q_full;

	assign pos_w    = PW'(req.position);
	assign cnt_w    = PW'(count_q);
	assign cnt_m1   = count_q - ONE_C;
	assign last     = cnt_m1[AW-1:0];
	assign item_ext = {{DATA_WIDTH{1'b0}}, req.item_in};
	assign item     = item_ext[DATA_WIDTH-1:0];

	// Classify the request against the current count
	always_comb begin
		ctrl.kind   = K_NONE;
		ctrl.status = ST_OK;
		ctrl.shift  = 1'b0;
		cnt_next    = count_q;
		addr        = pos_w[AW-1:0];
		unique case (req.req_type)
			OP_APPEND: begin
				addr = count_q[AW-1:0];
				if (count_q == DEPTH_C) begin
					ctrl.status = ST_FULL;
				end else begin
					ctrl.kind = K_WRITE;
					cnt_next  = count_q + ONE_C;
				end
			end
			OP_INSERT: begin
				if (pos_w > cnt_w) begin
					ctrl.status = ST_BAD_INDEX;
				end else if (count_q == DEPTH_C) begin
					ctrl.status = ST_FULL;
				end else begin
					ctrl.kind  = K_INS;
					ctrl.shift = pos_w < cnt_w;
					cnt_next   = count_q + ONE_C;
				end
			end
			OP_GET, OP_SET, OP_REMOVE: begin
				if (count_q == '0) begin
					ctrl.status = ST_EMPTY;
				end else if (pos_w >= cnt_w) begin
					ctrl.status = ST_BAD_INDEX;
				end else if (req.req_type == OP_GET) begin
					ctrl.kind = K_GET;
				end else if (req.req_type == OP_SET) begin
					ctrl.kind = K_SET;
				end else begin
					ctrl.kind  = K_REM;
					ctrl.shift = (pos_w + ONE_P) < cnt_w;
					cnt_next   = cnt_m1;
				end
			end
			OP_CLEAR: begin
				cnt_next = '0;
			end
			default: begin
				cnt_next = count_q;
			end
		endcase
		ctrl.count_after = 7'(cnt_next);
	end

	// Advance the live count on every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= cnt_next;
		end
	end

endmodule

FILE: rtl/core/ilir_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ilir_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ilir_cmd_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;

	assign dout  = slot_q[rd_ptr_q];
	assign full  = fill_q == 2'd2;
	assign empty = fill_q == 2'd0;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/core/ilir_back.sv
// ----------------------------------------------------------------------------
// ilir_back
// Carries out queued commands on the entry memory: reads, writes and
// one-entry-per-cycle shifts, then presents the response in an output
// register.
// ----------------------------------------------------------------------------
module ilir_back import ilir_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  cmd_ctrl_t                ctrl_in,
	input  logic [$clog2(DEPTH)-1:0] addr_in,
	input  logic [$clog2(DEPTH)-1:0] last_in,
	input  logic [DATA_WIDTH-1:0]    item_in,
	output logic                     pop,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output rsp_t                     rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] ONE_A = AW'(1);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	back_state_t           state_q;
	back_state_t           state_d;
	cmd_ctrl_t             cmd_ctrl_q;
	logic [AW-1:0]         cmd_addr_q;
	logic [AW-1:0]         cmd_last_q;
	logic [DATA_WIDTH-1:0] cmd_item_q;
	logic [AW-1:0]         src_q;
	logic [AW-1:0]         end_q;
	logic [AW-1:0]         dst_q;
	logic                  pend_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic                  out_valid_q;
	rsp_t                  out_q;

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic                  re;
	logic [AW-1:0]         raddr;
	logic                  load;
	logic                  moving_up;
	logic [DATA_WIDTH+31:0] res_ext;

	assign moving_up = cmd_ctrl_q.kind == K_INS;
	assign res_ext   = {32'b0, res_q};
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Next state and memory control
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		we      = 1'b0;
		waddr   = cmd_addr_q;
		wdata   = cmd_item_q;
		re      = 1'b0;
		raddr   = cmd_addr_q;
		load    = 1'b0;
		if (pend_q) begin
			we    = 1'b1;
			waddr = dst_q;
			wdata = rd_q;
		end
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					unique case (ctrl_in.kind)
						K_NONE:               state_d = B_EMIT;
						K_WRITE:              state_d = B_WRITE;
						K_GET, K_SET, K_REM:  state_d = B_READ;
						K_INS:                state_d = ctrl_in.shift ? B_MOVE : B_WRITE;
						default:              state_d = B_EMIT;
					endcase
				end
			end
			B_READ: begin
				re      = 1'b1;
				raddr   = cmd_addr_q;
				state_d = B_CAP;
			end
			B_CAP: begin
				if (cmd_ctrl_q.kind == K_SET) begin
					we    = 1'b1;
					waddr = cmd_addr_q;
					wdata = cmd_item_q;
				end
				if (cmd_ctrl_q.kind == K_REM && cmd_ctrl_q.shift) begin
					state_d = B_MOVE;
				end else begin
					state_d = B_EMIT;
				end
			end
			B_MOVE: begin
				re    = 1'b1;
				raddr = src_q;
				if (src_q == end_q) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: begin
				state_d = moving_up ? B_WRITE : B_EMIT;
			end
			B_WRITE: begin
				we      = 1'b1;
				waddr   = cmd_addr_q;
				wdata   = cmd_item_q;
				state_d = B_EMIT;
			end
			B_EMIT: begin
				if (!out_valid_q || !rsp_stall) begin
					load    = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Write and read the entry memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// The pending shift write lands in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= state_q == B_MOVE;
		end
	end

	// Latch the command and step the shift pointers
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_ctrl_q <= ctrl_in;
			cmd_addr_q <= addr_in;
			cmd_last_q <= last_in;
			cmd_item_q <= item_in;
			res_q      <= '0;
			src_q      <= last_in;
			end_q      <= addr_in;
		end
		if (state_q == B_CAP) begin
			res_q <= rd_q;
			src_q <= cmd_addr_q + ONE_A;
			end_q <= cmd_last_q;
		end
		if (state_q == B_MOVE) begin
			dst_q <= moving_up ? src_q + ONE_A : src_q - ONE_A;
			if (src_q != end_q) begin
				src_q <= moving_up ? src_q - ONE_A : src_q + ONE_A;
			end
		end
	end

	// Output register: drop when taken, load when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.status      <= cmd_ctrl_q.status;
			out_q.item_out    <= res_ext[31:0];
			out_q.count_after <= cmd_ctrl_q.count_after;
		end
	end

endmodule

FILE: rtl/core/indexed_list_insert_remove.sv
// Each request is classified by the front end and queued; the back end pops a command
// only when idle and finishes it, any shift and the response load included, before it
// takes the next. Shifts move one entry per cycle through the entry memory's separate
// read and write ports. The front end runs ahead through a 2-deep queue.
// Reset clears the count, queue, engine state and output valid; entries are not cleared.
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Ordered list of up to DEPTH words with append, insert, get, set, remove
// and clear requests, split into a classifying front end and a memory back end.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove import ilir_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int QW = $bits(cmd_ctrl_t) + 2 * AW + DATA_WIDTH;

	cmd_ctrl_t             f_ctrl;
	logic [AW-1:0]         f_addr;
	logic [AW-1:0]         f_last;
	logic [DATA_WIDTH-1:0] f_item;
	logic                  push;
	logic                  pop;
	logic                  q_full;
	logic                  q_empty;
	logic [QW-1:0]         q_din;
	logic [QW-1:0]         q_dout;
	cmd_ctrl_t             b_ctrl;
	logic [AW-1:0]         b_addr;
	logic [AW-1:0]         b_last;
	logic [DATA_WIDTH-1:0] b_item;

	ilir_front #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.ctrl      (f_ctrl),
		.addr      (f_addr),
		.last      (f_last),
		.item      (f_item)
	);

	// Pack the command for the queue
	assign q_din = {f_ctrl, f_addr, f_last, f_item};
	assign {b_ctrl, b_addr, b_last, b_item} = q_dout;

	ilir_cmd_fifo #(
		.WIDTH (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_din),
		.pop    (pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	ilir_back #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.ctrl_in   (b_ctrl),
		.addr_in   (b_addr),
		.last_in   (b_last),
		.item_in   (b_item),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: sim/indexed_list_insert_remove_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_test
// Self-checking bench for the indexed list. A behavioral copy of the list
// predicts every response, and the bench checks each response against it in
// order. Directed requests cover the empty list, a small list and the spare
// codes. Random fill and drain sequences reach a full list, then a random mix
// runs; idle cycles and response stalls are random outside one steady round.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_test;
	import ilir_pkg::*;

	localparam int DEPTH       = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 100;

	// Request codes the block treats as no-ops
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Predicted list contents and pending responses
	logic [DATA_WIDTH-1:0] list_words [DEPTH];
	int unsigned list_count;
	rsp_t pending_rsp [$];
	int unsigned error_count;
	int unsigned quiet_cycles;
	bit steady_run;

	indexed_list_insert_remove #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the list copy and return its response
	function automatic rsp_t apply_list_request(input req_t r);
		rsp_t o;
		int unsigned idx;
		int unsigned j;
		o.status = ST_OK;
		o.item_out = '0;
		idx = r.position;
		case (r.req_type)
			OP_APPEND: begin
				if (list_count >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					list_words[list_count] = r.item_in;
					list_count++;
				end
			end
			OP_INSERT: begin
				if (idx > list_count) begin
					o.status = ST_BAD_INDEX;
				end else if (list_count >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					for (j = list_count; j > idx; j--)
						list_words[j] = list_words[j - 1];
					list_words[idx] = r.item_in;
					list_count++;
				end
			end
			OP_GET, OP_SET, OP_REMOVE: begin
				if (list_count == 0) begin
					o.status = ST_EMPTY;
				end else if (idx >= list_count) begin
					o.status = ST_BAD_INDEX;
				end else begin
					o.item_out = list_words[idx];
					if (r.req_type == OP_SET) begin
						list_words[idx] = r.item_in;
					end else if (r.req_type == OP_REMOVE) begin
						for (j = idx; j + 1 < list_count; j++)
							list_words[j] = list_words[j + 1];
						list_count--;
					end
				end
			end
			OP_CLEAR: begin
				list_count = 0;
			end
			default: begin
			end
		endcase
		o.count_after = list_count[6:0];
		return o;
	endfunction

	// Send one request, idling at random first; predict it once accepted
	task automatic send_request(input logic [2:0] op, input logic [6:0] pos,
			input logic [31:0] word);
		req_t r;
		r.req_type = op;
		r.position = pos;
		r.item_in = word;
		while (!steady_run && $urandom_range(99) < 24) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		pending_rsp.push_back(apply_list_request(r));
	endtask

	// Pick an index that is mostly in range for the operation
	function automatic logic [6:0] pick_position(input logic [2:0] op);
		if ($urandom_range(99) < 10)
			return 7'($urandom_range(127));
		if (op == OP_INSERT)
			return 7'($urandom_range(list_count));
		if (list_count == 0)
			return 7'd0;
		return 7'($urandom_range(list_count - 1));
	endfunction

	// Response stall: random, except through the steady stretch
	always @(posedge clk)
		rsp_stall <= !steady_run && ($urandom_range(99) < 24);

	// Check each response against the oldest prediction
	always @(posedge clk) begin : check_responses
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("response with no request pending: status %0d item_out %h",
					rsp.status, rsp.item_out);
				error_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					error_count++;
				end
				if (rsp.item_out !== want.item_out) begin
					$error("item_out: expected %h, got %h", want.item_out, rsp.item_out);
					error_count++;
				end
				if (rsp.count_after !== want.count_after) begin
					$error("count_after: expected %0d, got %0d",
						want.count_after, rsp.count_after);
					error_count++;
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("indexed_list_insert_remove verification failed");
				$finish;
			end
		end
	end

	// Get, set, remove and a bad insert on an empty list, plus clear and spare codes
	task automatic test_empty_list();
		send_request(OP_GET, 7'd0, 32'h0);
		send_request(OP_SET, 7'd0, 32'hFFFF_FFFF);
		send_request(OP_REMOVE, 7'd0, 32'h0);
		send_request(OP_GET, 7'd127, 32'h0);
		send_request(OP_INSERT, 7'd1, 32'h1234_5678);
		send_request(OP_CLEAR, 7'd0, 32'h0);
		send_request(OP_SPARE_A, 7'd127, 32'hFFFF_FFFF);
		send_request(OP_SPARE_B, 7'd64, 32'h8000_0001);
	endtask

	// Every operation on a short list, at both ends and in the middle
	task automatic test_small_list();
		send_request(OP_APPEND, 7'd0, 32'h0000_0000);
		send_request(OP_APPEND, 7'd127, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 7'd0, 32'hA5A5_A5A5);
		send_request(OP_INSERT, 7'd3, 32'h5A5A_5A5A);
		send_request(OP_INSERT, 7'd2, 32'h0F0F_F0F0);
		send_request(OP_INSERT, 7'd6, 32'hDEAD_BEEF);
		send_request(OP_GET, 7'd0, 32'h0);
		send_request(OP_GET, 7'd4, 32'h0);
		send_request(OP_GET, 7'd5, 32'h0);
		send_request(OP_SET, 7'd1, 32'hFFFF_FFFF);
		send_request(OP_SET, 7'd64, 32'h0);
		send_request(OP_REMOVE, 7'd0, 32'h0);
		send_request(OP_REMOVE, 7'd3, 32'h0);
		send_request(OP_REMOVE, 7'd1, 32'h0);
		send_request(OP_CLEAR, 7'd99, 32'hFFFF_FFFF);
		send_request(OP_GET, 7'd0, 32'h0);
	endtask

	// Fill to full with random words, probe the full list, drain it again
	task automatic test_fill_and_drain(input int rounds);
		int r;
		int unsigned roll;
		logic [2:0] op;
		for (r = 0; r < rounds; r++) begin
			steady_run = (r == 1);
			while (list_count < DEPTH) begin
				roll = $urandom_range(99);
				op = roll < 50 ? OP_APPEND : roll < 90 ? OP_INSERT : OP_GET;
				send_request(op, pick_position(op), $urandom());
			end
			send_request(OP_APPEND, 7'($urandom_range(127)), $urandom());
			send_request(OP_INSERT, 7'($urandom_range(DEPTH)), $urandom());
			send_request(OP_INSERT, 7'($urandom_range(127, DEPTH + 1)), $urandom());
			send_request(OP_GET, 7'(DEPTH - 1), $urandom());
			send_request(OP_GET, 7'(DEPTH), $urandom());
			send_request(OP_SET, pick_position(OP_SET), $urandom());
			while (list_count > 0) begin
				roll = $urandom_range(99);
				op = roll < 85 ? OP_REMOVE : roll < 93 ? OP_GET : OP_SET;
				send_request(op, pick_position(op), $urandom());
			end
		end
		steady_run = 1'b0;
	endtask

	// Phases that lean toward growth, shrinkage or neither
	task automatic test_random_mix(input int n_items);
		int k;
		int unsigned roll;
		mix_mode_t mode;
		logic [2:0] op;
		mode = MIX_EVEN;
		for (k = 0; k < n_items; k++) begin
			if (k % 50 == 0)
				mode = mix_mode_t'($urandom_range(2));
			roll = $urandom_range(99);
			case (mode)
				MIX_GROW:
					op = roll < 45 ? OP_APPEND : roll < 80 ? OP_INSERT :
						roll < 88 ? OP_GET : roll < 95 ? OP_SET : OP_REMOVE;
				MIX_SHRINK:
					op = roll < 15 ? OP_APPEND : roll < 30 ? OP_INSERT :
						roll < 45 ? OP_GET : roll < 55 ? OP_SET :
						roll < 97 ? OP_REMOVE : OP_CLEAR;
				default:
					op = roll < 20 ? OP_APPEND : roll < 40 ? OP_INSERT :
						roll < 55 ? OP_GET : roll < 70 ? OP_SET :
						roll < 92 ? OP_REMOVE : roll < 95 ? OP_CLEAR :
						roll < 98 ? OP_SPARE_A : OP_SPARE_B;
			endcase
			send_request(op, pick_position(op), $urandom());
		end
	endtask

	initial begin
		req_valid = 1'b0;
		req = '0;
		list_count = 0;
		error_count = 0;
		steady_run = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_small_list();
		test_fill_and_drain(3);
		test_random_mix(250);

		// Drop valid, then wait out every pending response
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0)
			$display("indexed_list_insert_remove verification clean");
		else
			$display("indexed_list_insert_remove verification failed");
		$finish;
	end

endmodule
